@@ src/dlle_pkg.sv @@
`default_nettype none

package dlle_pkg;

  // Number of list nodes held in the node memories.
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned PTR_W    = IDX_W + 1;
  localparam int unsigned VAL_W    = 32;

  typedef logic [IDX_W-1:0] idx_t;
  // A link is a node index with a null flag in its top bit.
  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t NIL_PTR = ptr_t'({1'b1, {IDX_W{1'b0}}});

  typedef enum logic [1:0] {
    FN_DISPLAY   = 2'd0,
    FN_INS_FRONT = 2'd1,
    FN_INS_BACK  = 2'd2,
    FN_DELETE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_NODE,
    S_INS_LINK,
    S_UNLINK,
    S_RESP
  } state_t;

  // Write side of the node memories; each array has its own port.
  typedef struct packed {
    logic             val_we;
    idx_t             val_addr;
    logic [VAL_W-1:0] value;
    logic             fwd_we;
    idx_t             fwd_addr;
    ptr_t             fwd;
    logic             bwd_we;
    idx_t             bwd_addr;
    ptr_t             bwd;
  } node_wr_t;

  // Registered read data of one node.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    ptr_t             fwd;
    ptr_t             bwd;
  } node_rd_t;

  function automatic logic is_node(input ptr_t p);
    return !p[IDX_W];
  endfunction

  // Lowest-numbered set bit of the free map.
  function automatic idx_t lowest_free(input logic [CAPACITY-1:0] m);
    idx_t r;
    r = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = idx_t'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/dlle_node_mem.sv @@
`default_nettype none

module dlle_node_mem (
  input  wire                     clk,
  input  wire                     rd_en,
  input  wire dlle_pkg::idx_t     rd_addr,
  input  wire dlle_pkg::node_wr_t wr,
  output dlle_pkg::node_rd_t      rd
);

  logic [dlle_pkg::VAL_W-1:0] val_mem [dlle_pkg::CAPACITY];
  dlle_pkg::ptr_t             fwd_mem [dlle_pkg::CAPACITY];
  dlle_pkg::ptr_t             bwd_mem [dlle_pkg::CAPACITY];
  dlle_pkg::node_rd_t         rd_r;

  // One write port per array.
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[wr.val_addr] <= wr.value;
    end
    if (wr.fwd_we) begin
      fwd_mem[wr.fwd_addr] <= wr.fwd;
    end
    if (wr.bwd_we) begin
      bwd_mem[wr.bwd_addr] <= wr.bwd;
    end
  end

  // Shared read address; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.value <= val_mem[rd_addr];
      rd_r.fwd   <= fwd_mem[rd_addr];
      rd_r.bwd   <= bwd_mem[rd_addr];
    end
  end

  assign rd = rd_r;

endmodule

`default_nettype wire

@@ src/doubly_linked_list_engine_unit.sv @@
`default_nettype none

// Channel  Direction  tdata               tuser        tlast
// in       in         [31:0] item_value   [1:0] func   -
// out      out        [31:0] element_value [1:0] status last_result
//
// One request at a time. Insert writes the new node and then links it; a full list
// goes straight to its result. Display returns one result per element; delete walks
// to the match and unlinks it. A walk reads one node per cycle along forward links.
// Reset (rst_n low, synchronous) empties the list and frees every node.
// A stalled output pauses a display walk or a closing result; a new request is
// taken only once the previous one has placed its last result in the output register.

module doubly_linked_list_engine_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // [31:0] item_value
  input  wire [1:0]  in_tuser,   // [1:0] func
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata, // [31:0] element_value
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);

  dlle_pkg::state_t             state_r, state_nxt;
  dlle_pkg::func_t              func_r, func_nxt;
  logic [dlle_pkg::VAL_W-1:0]   val_r, val_nxt;
  dlle_pkg::idx_t               cur_r, cur_nxt;
  dlle_pkg::idx_t               cnt_r, cnt_nxt;
  dlle_pkg::idx_t               new_r, new_nxt;
  dlle_pkg::status_t            resp_st_r, resp_st_nxt;
  dlle_pkg::ptr_t               first_r, first_nxt;
  dlle_pkg::ptr_t               final_r, final_nxt;
  logic [dlle_pkg::CAPACITY-1:0] free_r, free_nxt;

  logic                         out_valid_r;
  logic [dlle_pkg::VAL_W-1:0]   out_data_r;
  dlle_pkg::status_t            out_st_r;
  logic                         out_last_r;

  logic                         emit;
  logic [dlle_pkg::VAL_W-1:0]   emit_val;
  dlle_pkg::status_t            emit_st;
  logic                         emit_last;
  logic                         out_free;
  logic                         in_acc;
  logic                         walk_end;

  logic                         rd_en;
  dlle_pkg::idx_t               rd_addr;
  dlle_pkg::node_wr_t           wr;
  dlle_pkg::node_rd_t           rd;

  dlle_node_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;
  // The walk stops at the tail or after CAPACITY nodes.
  assign walk_end = !dlle_pkg::is_node(rd.fwd) ||
                    (({1'b0, cnt_r} + 1'b1) == dlle_pkg::ptr_t'(dlle_pkg::CAPACITY));

  // State register and list pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlle_pkg::S_IDLE;
      first_r <= dlle_pkg::NIL_PTR;
      final_r <= dlle_pkg::NIL_PTR;
      free_r  <= '1;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      final_r <= final_nxt;
      free_r  <= free_nxt;
    end
  end

  // Request payload and walk position.
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    val_r     <= val_nxt;
    cur_r     <= cur_nxt;
    cnt_r     <= cnt_nxt;
    new_r     <= new_nxt;
    resp_st_r <= resp_st_nxt;
  end

  // Sequencer: next state, memory accesses and result requests.
  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    val_nxt     = val_r;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    new_nxt     = new_r;
    resp_st_nxt = resp_st_r;
    first_nxt   = first_r;
    final_nxt   = final_r;
    free_nxt    = free_r;
    in_tready   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cur_r;
    wr          = '0;
    wr.val_addr = new_r;
    wr.fwd_addr = new_r;
    wr.bwd_addr = new_r;
    wr.value    = val_r;
    emit        = 1'b0;
    emit_val    = rd.value;
    emit_st     = dlle_pkg::ST_OK;
    emit_last   = 1'b1;

    case (state_r)
      dlle_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          func_nxt = dlle_pkg::func_t'(in_tuser);
          val_nxt  = in_tdata;
          cur_nxt  = first_r[dlle_pkg::IDX_W-1:0];
          cnt_nxt  = '0;
          new_nxt  = dlle_pkg::lowest_free(free_r);
          case (dlle_pkg::func_t'(in_tuser))
            dlle_pkg::FN_INS_FRONT, dlle_pkg::FN_INS_BACK: begin
              if (free_r == '0) begin
                resp_st_nxt = dlle_pkg::ST_FULL;
                state_nxt   = dlle_pkg::S_RESP;
              end else begin
                state_nxt = dlle_pkg::S_INS_NODE;
              end
            end
            default: begin
              // Display and delete walk from the head.
              if (dlle_pkg::is_node(first_r)) begin
                rd_en     = 1'b1;
                rd_addr   = first_r[dlle_pkg::IDX_W-1:0];
                state_nxt = dlle_pkg::S_WALK;
              end else begin
                resp_st_nxt = (dlle_pkg::func_t'(in_tuser) == dlle_pkg::FN_DISPLAY) ?
                              dlle_pkg::ST_EMPTY : dlle_pkg::ST_NOT_FOUND;
                state_nxt   = dlle_pkg::S_RESP;
              end
            end
          endcase
        end
      end

      dlle_pkg::S_WALK: begin
        if (func_r == dlle_pkg::FN_DISPLAY) begin
          // One element per cycle while the output register can take it.
          if (out_free) begin
            emit      = 1'b1;
            emit_last = walk_end;
            if (walk_end) begin
              state_nxt = dlle_pkg::S_IDLE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = rd.fwd[dlle_pkg::IDX_W-1:0];
              cur_nxt = rd.fwd[dlle_pkg::IDX_W-1:0];
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end else if (rd.value == val_r) begin
          state_nxt = dlle_pkg::S_UNLINK;
        end else if (walk_end) begin
          resp_st_nxt = dlle_pkg::ST_NOT_FOUND;
          state_nxt   = dlle_pkg::S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd.fwd[dlle_pkg::IDX_W-1:0];
          cur_nxt = rd.fwd[dlle_pkg::IDX_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      dlle_pkg::S_INS_NODE: begin
        // Fill the new node; its links point outward from the chosen end.
        wr.val_we = 1'b1;
        wr.fwd_we = 1'b1;
        wr.bwd_we = 1'b1;
        if (func_r == dlle_pkg::FN_INS_FRONT) begin
          wr.fwd = first_r;
          wr.bwd = dlle_pkg::NIL_PTR;
        end else begin
          wr.fwd = dlle_pkg::NIL_PTR;
          wr.bwd = final_r;
        end
        free_nxt[new_r] = 1'b0;
        state_nxt       = dlle_pkg::S_INS_LINK;
      end

      dlle_pkg::S_INS_LINK: begin
        // Link the old end node to the new node, which becomes the new end (or both ends).
        if (func_r == dlle_pkg::FN_INS_FRONT) begin
          if (dlle_pkg::is_node(first_r)) begin
            wr.bwd_we   = 1'b1;
            wr.bwd_addr = first_r[dlle_pkg::IDX_W-1:0];
            wr.bwd      = {1'b0, new_r};
          end else begin
            final_nxt = {1'b0, new_r};
          end
          first_nxt = {1'b0, new_r};
        end else begin
          if (dlle_pkg::is_node(final_r)) begin
            wr.fwd_we   = 1'b1;
            wr.fwd_addr = final_r[dlle_pkg::IDX_W-1:0];
            wr.fwd      = {1'b0, new_r};
          end else begin
            first_nxt = {1'b0, new_r};
          end
          final_nxt = {1'b0, new_r};
        end
        resp_st_nxt = dlle_pkg::ST_OK;
        state_nxt   = dlle_pkg::S_RESP;
      end

      dlle_pkg::S_UNLINK: begin
        // Bridge the neighbors of the matched node and free it.
        if (dlle_pkg::is_node(rd.bwd)) begin
          wr.fwd_we   = 1'b1;
          wr.fwd_addr = rd.bwd[dlle_pkg::IDX_W-1:0];
          wr.fwd      = rd.fwd;
        end else begin
          first_nxt = rd.fwd;
        end
        if (dlle_pkg::is_node(rd.fwd)) begin
          wr.bwd_we   = 1'b1;
          wr.bwd_addr = rd.fwd[dlle_pkg::IDX_W-1:0];
          wr.bwd      = rd.bwd;
        end else begin
          final_nxt = rd.bwd;
        end
        free_nxt[cur_r] = 1'b1;
        resp_st_nxt     = dlle_pkg::ST_OK;
        state_nxt       = dlle_pkg::S_RESP;
      end

      dlle_pkg::S_RESP: begin
        // Single closing result; an empty display reports zero.
        if (out_free) begin
          emit      = 1'b1;
          emit_st   = resp_st_r;
          emit_val  = (func_r == dlle_pkg::FN_DISPLAY) ? '0 : val_r;
          state_nxt = dlle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dlle_pkg::S_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_val;
      out_st_r   <= emit_st;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // Head and tail pointers are null together.
  a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
    first_r[dlle_pkg::IDX_W] == final_r[dlle_pkg::IDX_W])
    else $error("head and tail null flags disagree");

  // An empty list owns no node, except while an insert is being linked.
  a_empty_all_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!dlle_pkg::is_node(first_r) && state_r != dlle_pkg::S_INS_LINK) |-> (free_r == '1))
    else $error("empty list with nodes in use");

  // Node memories are written only by the insert and unlink steps.
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.val_we || wr.fwd_we || wr.bwd_we) |->
    (state_r == dlle_pkg::S_INS_NODE || state_r == dlle_pkg::S_INS_LINK ||
     state_r == dlle_pkg::S_UNLINK))
    else $error("node memory written outside an update step");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !emit)
    else $error("pending result overwritten");

  // A request is taken only after the previous one has closed with a last result.
  a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(emit) && !$past(emit_last) |-> !in_tready)
    else $error("request accepted in the middle of a display");
`endif

endmodule

`default_nettype wire
